[sv/chsi_pkg.sv]
package chsi_pkg;

  localparam int INIT_BUCKETS = 2048;
  localparam int MAX_BUCKETS  = 8192;
  localparam int POOL_ENTRIES = 16384;
  localparam int KEY_W        = 64;

  localparam int BKT_W   = $clog2(MAX_BUCKETS);
  localparam int NODE_W  = $clog2(POOL_ENTRIES);
  localparam int LINK_W  = $clog2(POOL_ENTRIES + 1);
  localparam int INIT_LOG_RAW = $clog2(INIT_BUCKETS);
  localparam int INIT_LOG = (INIT_LOG_RAW > BKT_W) ? BKT_W : INIT_LOG_RAW;
  localparam int LOG_W   = $clog2(BKT_W + 2);
  localparam int HANDLE_W = 32;
  localparam int HASH_W   = 32;
  localparam int DATA_W   = KEY_W + HANDLE_W + HASH_W;
  localparam int CMP_W    = LINK_W + 2;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_HEAD,
    ST_NODE,
    ST_MISS,
    ST_LINK,
    ST_RESP,
    ST_RH_CLR,
    ST_RH_RD,
    ST_RH_HASH,
    ST_RH_WR
  } state_t;

  function automatic logic [BKT_W-1:0] mask_of(input logic [LOG_W-1:0] lg);
    mask_of = ~({BKT_W{1'b1}} << lg);
  endfunction

endpackage

[sv/chained_hash_set_insert.sv]
// Steps: after accept the bucket head is read, then each chain node is visited in turn;
// a miss then writes the new node and, for an empty chain, the bucket head, or to append, the old tail's link.
// One request at a time; a new one is taken once the previous result is loaded.
// After an insert that doubles the table, a rebuild clears the new buckets and
// relinks every element before the next accept.
// Reset (rst, synchronous) clears the 2048 initial buckets.
module chained_hash_set_insert (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] key_value,
  input  logic [31:0] key_handle,
  input  logic [31:0] key_hash,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [31:0] existing_handle,
  output logic        pool_full
);

  chsi_pkg::state_t state, state_next;

  logic [chsi_pkg::KEY_W-1:0]    key, key_next;
  logic [31:0]                   handle, handle_next;
  logic [31:0]                   hash, hash_next;
  logic [chsi_pkg::BKT_W-1:0]    place, place_next;
  logic [chsi_pkg::LINK_W-1:0]   cur, cur_next;
  logic [chsi_pkg::LINK_W-1:0]   last, last_next;
  logic [chsi_pkg::LINK_W-1:0]   count, count_next;
  logic [chsi_pkg::LOG_W-1:0]    size_log, size_log_next;
  logic [chsi_pkg::BKT_W-1:0]    idx, idx_next;
  logic [chsi_pkg::NODE_W-1:0]   rn, rn_next;
  logic                          grow, grow_next;
  logic                          r_found, r_found_next;
  logic [31:0]                   r_handle, r_handle_next;
  logic                          r_full, r_full_next;
  logic                          out_valid_next;

  // memory ports
  logic                          bk_we;
  logic [chsi_pkg::BKT_W-1:0]    bk_waddr, bk_raddr;
  logic [chsi_pkg::LINK_W-1:0]   bk_wdata, bk_rdata;
  logic                          nd_we;
  logic [chsi_pkg::NODE_W-1:0]   nd_waddr, nd_raddr;
  logic [chsi_pkg::DATA_W-1:0]   nd_wdata, nd_rdata;
  logic                          lk_we;
  logic [chsi_pkg::NODE_W-1:0]   lk_waddr, lk_raddr;
  logic [chsi_pkg::LINK_W-1:0]   lk_wdata, lk_rdata;

  logic [chsi_pkg::KEY_W-1:0]    nd_key;
  logic [31:0]                   nd_handle, nd_hash;
  logic [chsi_pkg::BKT_W-1:0]    cur_mask, new_mask;
  logic [chsi_pkg::LOG_W-1:0]    new_log;
  logic [chsi_pkg::LINK_W-1:0]   count_inc;
  logic [chsi_pkg::CMP_W-1:0]    twice_size;

  assign nd_key    = nd_rdata[chsi_pkg::DATA_W-1 -: chsi_pkg::KEY_W];
  assign nd_handle = nd_rdata[63:32];
  assign nd_hash   = nd_rdata[31:0];
  assign new_log   = size_log + chsi_pkg::LOG_W'(1);
  assign cur_mask  = chsi_pkg::mask_of(size_log);
  assign new_mask  = chsi_pkg::mask_of(new_log);
  assign count_inc = count + chsi_pkg::LINK_W'(1);
  assign twice_size = chsi_pkg::CMP_W'(1) << new_log;

  chsi_ram #(.W(chsi_pkg::LINK_W), .D(chsi_pkg::MAX_BUCKETS)) u_heads (
    .clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
    .raddr(bk_raddr), .rdata(bk_rdata)
  );

  chsi_ram #(.W(chsi_pkg::DATA_W), .D(chsi_pkg::POOL_ENTRIES)) u_data (
    .clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
    .raddr(nd_raddr), .rdata(nd_rdata)
  );

  chsi_ram #(.W(chsi_pkg::LINK_W), .D(chsi_pkg::POOL_ENTRIES)) u_links (
    .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
    .raddr(lk_raddr), .rdata(lk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= chsi_pkg::ST_CLR;
      count     <= '0;
      size_log  <= chsi_pkg::LOG_W'(chsi_pkg::INIT_LOG);
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      size_log  <= size_log_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
    key      <= key_next;
    handle   <= handle_next;
    hash     <= hash_next;
    place    <= place_next;
    cur      <= cur_next;
    last     <= last_next;
    rn       <= rn_next;
    grow     <= grow_next;
    r_found  <= r_found_next;
    r_handle <= r_handle_next;
    r_full   <= r_full_next;
    // output payload changes only when a new result is loaded
    if (state == chsi_pkg::ST_RESP && (!out_valid || !out_stall)) begin
      found           <= r_found;
      existing_handle <= r_handle;
      pool_full       <= r_full;
    end
  end

  always_comb begin
    state_next     = state;
    key_next       = key;
    handle_next    = handle;
    hash_next      = hash;
    place_next     = place;
    cur_next       = cur;
    last_next      = last;
    count_next     = count;
    size_log_next  = size_log;
    idx_next       = idx;
    rn_next        = rn;
    grow_next      = grow;
    r_found_next   = r_found;
    r_handle_next  = r_handle;
    r_full_next    = r_full;
    out_valid_next = out_valid && out_stall;
    in_stall       = 1'b1;

    bk_we    = 1'b0;
    bk_waddr = place;
    bk_wdata = '0;
    bk_raddr = place;
    nd_we    = 1'b0;
    nd_waddr = count[chsi_pkg::NODE_W-1:0];
    nd_wdata = {key, handle, hash};
    nd_raddr = rn;
    lk_we    = 1'b0;
    lk_waddr = count[chsi_pkg::NODE_W-1:0];
    lk_wdata = '0;
    lk_raddr = rn;

    case (state)
      chsi_pkg::ST_CLR: begin
        bk_we    = 1'b1;
        bk_waddr = idx;
        idx_next = idx + chsi_pkg::BKT_W'(1);
        if (idx == cur_mask) begin
          idx_next   = '0;
          state_next = chsi_pkg::ST_IDLE;
        end
      end
      chsi_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        bk_raddr = key_hash[chsi_pkg::BKT_W-1:0] & cur_mask;
        if (in_valid) begin
          key_next    = key_value[chsi_pkg::KEY_W-1:0];
          handle_next = key_handle;
          hash_next   = key_hash;
          place_next  = key_hash[chsi_pkg::BKT_W-1:0] & cur_mask;
          last_next   = '0;
          state_next  = chsi_pkg::ST_HEAD;
        end
      end
      chsi_pkg::ST_HEAD: begin
        cur_next = bk_rdata;
        nd_raddr = chsi_pkg::NODE_W'(bk_rdata - chsi_pkg::LINK_W'(1));
        lk_raddr = nd_raddr;
        if (bk_rdata == '0) begin
          state_next = chsi_pkg::ST_MISS;
        end else begin
          state_next = chsi_pkg::ST_NODE;
        end
      end
      chsi_pkg::ST_NODE: begin
        nd_raddr = chsi_pkg::NODE_W'(lk_rdata - chsi_pkg::LINK_W'(1));
        lk_raddr = nd_raddr;
        if (nd_hash == hash && nd_key == key) begin
          r_found_next  = 1'b1;
          r_handle_next = nd_handle;
          r_full_next   = 1'b0;
          grow_next     = 1'b0;
          state_next    = chsi_pkg::ST_RESP;
        end else begin
          last_next = cur;
          cur_next  = lk_rdata;
          if (lk_rdata == '0) begin
            state_next = chsi_pkg::ST_MISS;
          end
        end
      end
      chsi_pkg::ST_MISS: begin
        r_found_next  = 1'b0;
        r_handle_next = '0;
        grow_next     = 1'b0;
        if (count == chsi_pkg::LINK_W'(chsi_pkg::POOL_ENTRIES)) begin
          r_full_next = 1'b1;
          state_next  = chsi_pkg::ST_RESP;
        end else begin
          r_full_next = 1'b0;
          nd_we       = 1'b1;
          lk_we       = 1'b1;
          count_next  = count_inc;
          grow_next   = (chsi_pkg::CMP_W'(count_inc) > twice_size) &&
                        (new_log <= chsi_pkg::LOG_W'(chsi_pkg::BKT_W));
          if (last == '0) begin
            bk_we      = 1'b1;
            bk_wdata   = count_inc;
            state_next = chsi_pkg::ST_RESP;
          end else begin
            state_next = chsi_pkg::ST_LINK;
          end
        end
      end
      chsi_pkg::ST_LINK: begin
        // append to tail: count already points past the new node
        lk_we      = 1'b1;
        lk_waddr   = chsi_pkg::NODE_W'(last - chsi_pkg::LINK_W'(1));
        lk_wdata   = count;
        state_next = chsi_pkg::ST_RESP;
      end
      chsi_pkg::ST_RESP: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          idx_next       = '0;
          state_next     = grow ? chsi_pkg::ST_RH_CLR : chsi_pkg::ST_IDLE;
        end
      end
      chsi_pkg::ST_RH_CLR: begin
        bk_we    = 1'b1;
        bk_waddr = idx;
        idx_next = idx + chsi_pkg::BKT_W'(1);
        if (idx == new_mask) begin
          idx_next   = '0;
          rn_next    = '0;
          state_next = chsi_pkg::ST_RH_RD;
        end
      end
      chsi_pkg::ST_RH_RD: begin
        nd_raddr   = rn;
        state_next = chsi_pkg::ST_RH_HASH;
      end
      chsi_pkg::ST_RH_HASH: begin
        bk_raddr   = nd_hash[chsi_pkg::BKT_W-1:0] & new_mask;
        place_next = bk_raddr;
        state_next = chsi_pkg::ST_RH_WR;
      end
      chsi_pkg::ST_RH_WR: begin
        // push node rn onto the front of its new bucket
        lk_we    = 1'b1;
        lk_waddr = rn;
        lk_wdata = bk_rdata;
        bk_we    = 1'b1;
        bk_waddr = place;
        bk_wdata = chsi_pkg::LINK_W'(rn) + chsi_pkg::LINK_W'(1);
        rn_next  = rn + chsi_pkg::NODE_W'(1);
        if (bk_wdata == count) begin
          size_log_next = new_log;
          state_next    = chsi_pkg::ST_IDLE;
        end else begin
          state_next = chsi_pkg::ST_RH_RD;
        end
      end
      default: begin
        state_next = chsi_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[sv/chsi_ram.sv]
module chsi_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
